// ----- hw/rtl/lpmr_pkg.sv -----
// lpmr_pkg: shared constants, codes and types of the length-prefixed message ring
`default_nettype none

package lpmr_pkg;

   // default ring depth in bytes
   localparam int unsigned DEPTH_DEFAULT = 4096;

   // field widths
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned ID_W     = 12;
   localparam int unsigned FILL_W   = 13;

   // configuration port
   localparam int unsigned ADDR_W    = 4;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned REG_IDX_W = 2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SHORT      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd5;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_HEAD_LEN = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MIN_LEN  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAX_LEN  = 2'd2;

   // register reset values
   localparam logic [LEN_W-1:0] HEAD_LEN_RESET = 16'd2;
   localparam logic [LEN_W-1:0] MIN_LEN_RESET  = 16'd2;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET  = 16'hFFFF;

   // configuration seen by the datapath
   typedef struct packed {
      logic [LEN_W-1:0] head_length;
      logic [LEN_W-1:0] min_message_length;
      logic [LEN_W-1:0] max_message_length;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    message_length;
      logic [ID_W-1:0]     message_id;
      logic [BYTE_W-1:0]   data_out;
      logic                last_byte;
      logic                has_message;
      logic [FILL_W-1:0]   fill_count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lpmr_if.sv -----
// lpmr_if: request and response channel interfaces of the message ring
`default_nettype none

interface lpmr_req_if;
   import lpmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   data_byte;
   logic [LEN_W-1:0]    chunk_length;

   modport source (output valid, output opcode, output data_byte, output chunk_length,
                   input ready);
   modport sink (input valid, input opcode, input data_byte, input chunk_length,
                 output ready);
endinterface

interface lpmr_rsp_if;
   import lpmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    message_length;
   logic [ID_W-1:0]     message_id;
   logic [BYTE_W-1:0]   data_out;
   logic                last_byte;
   logic                has_message;
   logic [FILL_W-1:0]   fill_count;

   modport source (output valid, output status, output message_length, output message_id,
                   output data_out, output last_byte, output has_message,
                   output fill_count, input ready);
   modport sink (input valid, input status, input message_length, input message_id,
                 input data_out, input last_byte, input has_message, input fill_count,
                 output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lpmr_ram.sv -----
// lpmr_ram: byte ring storage, one write port and one registered read port
`default_nettype none

module lpmr_ram #(
   parameter int unsigned DEPTH = lpmr_pkg::DEPTH_DEFAULT,
   parameter int unsigned WIDTH = lpmr_pkg::BYTE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lpmr_csr.sv -----
// lpmr_csr: APB-style register block holding the length limits
`default_nettype none

module lpmr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lpmr_pkg::ADDR_W-1:0]   paddr,
   input  logic [lpmr_pkg::DATA_W-1:0]   pwdata,
   output logic [lpmr_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output lpmr_pkg::cfg_type             cfg
);
   import lpmr_pkg::*;

   logic [LEN_W-1:0]     head_ff, head_in;
   logic [LEN_W-1:0]     min_ff, min_in;
   logic [LEN_W-1:0]     max_ff, max_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_strobe;

   assign reg_idx   = paddr[ADDR_W-1:2];
   assign wr_strobe = psel && penable && pwrite;
   assign pready    = 1'b1;

   // register write decode
   always_comb begin
      head_in = head_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (wr_strobe) begin
         unique case (reg_idx)
            REG_HEAD_LEN: begin
               head_in = pwdata[LEN_W-1:0];
            end
            REG_MIN_LEN: begin
               min_in = pwdata[LEN_W-1:0];
            end
            REG_MAX_LEN: begin
               max_in = pwdata[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_LEN_RESET;
         min_ff  <= MIN_LEN_RESET;
         max_ff  <= MAX_LEN_RESET;
      end else begin
         head_ff <= head_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
      end
   end

   // read-back mux
   always_comb begin
      unique case (reg_idx)
         REG_HEAD_LEN: prdata = DATA_W'(head_ff);
         REG_MIN_LEN:  prdata = DATA_W'(min_ff);
         REG_MAX_LEN:  prdata = DATA_W'(max_ff);
         default:      prdata = '0;
      endcase
   end

   assign cfg.head_length        = head_ff;
   assign cfg.min_message_length = min_ff;
   assign cfg.max_message_length = max_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/length_prefixed_message_ring.sv -----
// length_prefixed_message_ring: top level, sequencer around the byte ring memory
//
// Byte ring of DEPTH entries holding messages that start with a 16-bit big-endian
// length. Requests are taken one at a time through the ring memory, whose single
// read port is registered: a push byte, a clear and any request that fails its
// checks before touching memory finish in the idle state, a read of a message byte
// issues the memory read and takes the data in S_RDB, and a pop start reads the two
// header bytes one after the other through the same read port (S_HI, S_LO). A
// finished result sits in an output register, so the next request is taken while it
// waits; only when a second result is ready before the first is taken does the block
// hold that result and stop taking requests until the output register frees up. Push
// bytes before the last of a chunk give no response. The length limits are written
// through the APB port at 0x0, 0x4 and 0x8; the user must write them only while the
// block is idle, which it does not enforce. The ring needs no clearing after reset.
`default_nettype none

module length_prefixed_message_ring #(
   parameter int unsigned DEPTH = lpmr_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   lpmr_req_if.sink                    req_ch,
   lpmr_rsp_if.source                  rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lpmr_pkg::ADDR_W-1:0] paddr,
   input  logic [lpmr_pkg::DATA_W-1:0] pwdata,
   output logic [lpmr_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import lpmr_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HI   = 3'd1;
   localparam logic [2:0] S_LO   = 3'd2;
   localparam logic [2:0] S_RDB  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;

   cfg_type cfg;

   logic [2:0]        state_ff, state_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  chunk_rem_ff, chunk_rem_in;
   logic              chunk_acc_ff, chunk_acc_in;
   logic [LEN_W-1:0]  rd_rem_ff, rd_rem_in;
   logic              flag_ff, flag_in;
   logic [BYTE_W-1:0] hi_ff, hi_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   rsp_type           hold_ff, hold_in;

   logic              mem_we;
   logic              mem_re;
   logic [PTR_W-1:0]  mem_raddr;
   logic [BYTE_W-1:0] mem_q;

   logic              fin_valid;
   rsp_type           fin_res;
   logic              slot_free;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // configuration registers
   lpmr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ring storage
   lpmr_ram #(
      .DEPTH (DEPTH),
      .WIDTH (BYTE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wp_ff),
      .wr_data (req_ch.data_byte),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign slot_free    = !out_valid_ff || rsp_ch.ready;

   // request sequencer and ring bookkeeping
   always_comb begin
      logic             acc;
      logic [LEN_W-1:0] rem;
      logic [LEN_W-1:0] hdr_len;

      acc          = chunk_acc_ff;
      rem          = chunk_rem_ff;
      hdr_len      = {hi_ff, mem_q};
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      chunk_rem_in = chunk_rem_ff;
      chunk_acc_in = chunk_acc_ff;
      rd_rem_in    = rd_rem_ff;
      flag_in      = flag_ff;
      hi_in        = hi_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = rp_ff;
      fin_valid    = 1'b0;
      fin_res      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.opcode)
                  OP_PUSH: begin
                     if (chunk_rem_ff == '0 && req_ch.chunk_length == '0) begin
                        // empty chunk is refused outright
                        fin_valid      = 1'b1;
                        fin_res.status = ST_REJECTED;
                     end else begin
                        if (chunk_rem_ff == '0) begin
                           acc = (SUM_W'(cnt_ff) + SUM_W'(req_ch.chunk_length))
                                 < SUM_W'(DEPTH);
                           rem = req_ch.chunk_length;
                        end
                        chunk_acc_in = acc;
                        if (acc) begin
                           mem_we = 1'b1;
                           wp_in  = next_pos(wp_ff);
                           if (cnt_ff != CNT_W'(DEPTH)) begin
                              cnt_in = cnt_ff + 1'b1;
                           end
                           flag_in = SUM_W'(cnt_in) >= SUM_W'(cfg.min_message_length);
                        end
                        chunk_rem_in = rem - 1'b1;
                        if (rem == LEN_W'(1)) begin
                           fin_valid      = 1'b1;
                           fin_res.status = acc ? ST_OK : ST_REJECTED;
                        end
                     end
                  end
                  OP_POP: begin
                     fin_res.message_id = ID_W'(rp_ff);
                     if (rd_rem_ff != '0) begin
                        fin_valid      = 1'b1;
                        fin_res.status = ST_BUSY;
                     end else if (SUM_W'(cnt_ff) < SUM_W'(cfg.head_length)) begin
                        fin_valid      = 1'b1;
                        fin_res.status = ST_SHORT;
                     end else begin
                        // fetch the high header byte
                        mem_re   = 1'b1;
                        state_in = S_HI;
                     end
                  end
                  OP_READ: begin
                     if (rd_rem_ff == '0) begin
                        fin_valid      = 1'b1;
                        fin_res.status = ST_IDLE;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = S_RDB;
                     end
                  end
                  OP_CLEAR: begin
                     wp_in        = '0;
                     rp_in        = '0;
                     cnt_in       = '0;
                     chunk_rem_in = '0;
                     chunk_acc_in = 1'b0;
                     rd_rem_in    = '0;
                     flag_in      = 1'b0;
                     fin_valid    = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HI: begin
            // capture high byte, fetch the low one with wraparound
            hi_in     = mem_q;
            mem_re    = 1'b1;
            mem_raddr = next_pos(rp_ff);
            state_in  = S_LO;
         end
         S_LO: begin
            fin_valid          = 1'b1;
            fin_res.message_id = ID_W'(rp_ff);
            state_in           = S_IDLE;
            if (hdr_len < cfg.head_length || hdr_len > cfg.max_message_length) begin
               fin_res.status = ST_BAD_LENGTH;
            end else if (SUM_W'(cnt_ff) < SUM_W'(hdr_len)) begin
               fin_res.status = ST_SHORT;
            end else begin
               fin_res.message_length = hdr_len;
               rd_rem_in              = hdr_len;
            end
         end
         S_RDB: begin
            fin_valid        = 1'b1;
            fin_res.data_out = mem_q;
            fin_res.last_byte = (rd_rem_ff == LEN_W'(1));
            rp_in            = next_pos(rp_ff);
            rd_rem_in        = rd_rem_ff - 1'b1;
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end
            flag_in  = SUM_W'(cnt_in) >= SUM_W'(cfg.min_message_length);
            state_in = S_IDLE;
         end
         S_WAIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      fin_res.has_message = flag_in;
      fin_res.fill_count  = FILL_W'(cnt_in);

      // result with nowhere to go waits in the hold register
      if (fin_valid && !slot_free) begin
         state_in = S_WAIT;
      end
   end

   // output register and hold register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      hold_in      = hold_ff;
      if (fin_valid && slot_free) begin
         out_valid_in = 1'b1;
         out_in       = fin_res;
      end else if (fin_valid) begin
         hold_in = fin_res;
      end else if (state_ff == S_WAIT && slot_free) begin
         out_valid_in = 1'b1;
         out_in       = hold_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         chunk_rem_ff <= '0;
         chunk_acc_ff <= 1'b0;
         rd_rem_ff    <= '0;
         flag_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         chunk_rem_ff <= chunk_rem_in;
         chunk_acc_ff <= chunk_acc_in;
         rd_rem_ff    <= rd_rem_in;
         flag_ff      <= flag_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_ff.status;
   assign rsp_ch.message_length = out_ff.message_length;
   assign rsp_ch.message_id     = out_ff.message_id;
   assign rsp_ch.data_out       = out_ff.data_out;
   assign rsp_ch.last_byte      = out_ff.last_byte;
   assign rsp_ch.has_message    = out_ff.has_message;
   assign rsp_ch.fill_count     = out_ff.fill_count;

endmodule

`default_nettype wire

// ----- hw/rtl/lpmr_checker.sv -----
// lpmr_checker: port-level assertions for the message ring, bound to the top level
`default_nettype none

module lpmr_checker #(
   parameter int unsigned DEPTH = lpmr_pkg::DEPTH_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lpmr_pkg::STATUS_W-1:0]   rsp_status,
   input logic [lpmr_pkg::LEN_W-1:0]      rsp_message_length,
   input logic                            rsp_last_byte,
   input logic [lpmr_pkg::FILL_W-1:0]     rsp_fill_count
);
   import lpmr_pkg::*;

   // a response stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // nothing is offered straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // status is one of the defined codes and the fill never passes the ring size
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_IDLE) && (32'(rsp_fill_count) <= DEPTH))
      else $error("response status or fill count out of range");

   // the last byte of a message comes with ok status and no header length
   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte |-> (rsp_status == ST_OK) && (rsp_message_length == '0))
      else $error("last byte flagged on a non-data response");

endmodule

bind length_prefixed_message_ring lpmr_checker #(
   .DEPTH (DEPTH)
) u_lpmr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_message_length (rsp_ch.message_length),
   .rsp_last_byte      (rsp_ch.last_byte),
   .rsp_fill_count     (rsp_ch.fill_count)
);

`default_nettype wire

// ----- test/length_prefixed_message_ring_test.sv -----
// length_prefixed_message_ring_test: self-checking bench for the length-prefixed message ring
`timescale 1ns / 1ps

module length_prefixed_message_ring_test;
   import lpmr_pkg::*;

   localparam int unsigned RING_DEPTH    = DEPTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PRINT_CAP     = 50;

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   lpmr_req_if req_ch ();
   lpmr_rsp_if rsp_ch ();

   length_prefixed_message_ring u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // mirror of the ring contents, pointers and limits
   bit [BYTE_W-1:0]  mirror_bytes [RING_DEPTH];
   int unsigned      mirror_wr        = 0;
   int unsigned      mirror_rd        = 0;
   int unsigned      mirror_fill      = 0;
   int unsigned      chunk_bytes_left = 0;
   bit               chunk_taken      = 1'b0;
   int unsigned      msg_bytes_left   = 0;
   bit               msg_flag         = 1'b0;
   logic [LEN_W-1:0] lim_head         = HEAD_LEN_RESET;
   logic [LEN_W-1:0] lim_min          = MIN_LEN_RESET;
   logic [LEN_W-1:0] lim_max          = MAX_LEN_RESET;

   // responses owed by the ring, oldest first
   rsp_type     replies_due [$];
   rsp_type     last_reply;
   bit          last_reply_valid;

   int unsigned error_count     = 0;
   int unsigned requests_sent   = 0;
   int unsigned responses_seen  = 0;
   int unsigned status_seen [8];
   int unsigned cycle_count     = 0;
   int unsigned send_burst_left = 0;
   int unsigned recv_burst_left = 0;
   int unsigned hold_cycles_req = 0;

   // clock
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  replies_due.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string text);
      error_count++;
      if (error_count <= PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, text);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h (response %0d)", name, got, want,
                                   responses_seen));
   endtask

   // next state and response of the ring for one request
   function automatic bit compute_ring_reply(input logic [OPCODE_W-1:0] op,
                                             input logic [BYTE_W-1:0] data,
                                             input logic [LEN_W-1:0] clen,
                                             output rsp_type reply);
      int unsigned hdr_len;
      bit          emits;
      reply = '0;
      reply.status = ST_OK;
      emits = 1'b1;
      case (op)
         OP_PUSH: begin
            // zero length with no chunk open is refused on the spot
            if (chunk_bytes_left == 0 && clen == 0) begin
               reply.status = ST_REJECTED;
            end else begin
               // acceptance is decided once, on the first byte of a chunk
               if (chunk_bytes_left == 0) begin
                  chunk_taken = (mirror_fill + clen < RING_DEPTH);
                  chunk_bytes_left = clen;
               end
               if (chunk_taken) begin
                  mirror_bytes[mirror_wr] = data;
                  mirror_wr = (mirror_wr + 1) % RING_DEPTH;
                  if (mirror_fill < RING_DEPTH) mirror_fill++;
                  msg_flag = (mirror_fill >= lim_min);
               end
               chunk_bytes_left--;
               emits = (chunk_bytes_left == 0);
               reply.status = chunk_taken ? ST_OK : ST_REJECTED;
            end
         end
         OP_POP: begin
            reply.message_id = ID_W'(mirror_rd);
            if (msg_bytes_left != 0) begin
               reply.status = ST_BUSY;
            end else if (mirror_fill < lim_head) begin
               reply.status = ST_SHORT;
            end else begin
               // big-endian header, second byte may sit at the start of the ring
               hdr_len = {mirror_bytes[mirror_rd], mirror_bytes[(mirror_rd + 1) % RING_DEPTH]};
               if (hdr_len < lim_head || hdr_len > lim_max) begin
                  reply.status = ST_BAD_LENGTH;
               end else if (mirror_fill < hdr_len) begin
                  reply.status = ST_SHORT;
               end else begin
                  reply.message_length = LEN_W'(hdr_len);
                  msg_bytes_left = hdr_len;
               end
            end
         end
         OP_READ: begin
            if (msg_bytes_left == 0) begin
               reply.status = ST_IDLE;
            end else begin
               reply.data_out = mirror_bytes[mirror_rd];
               mirror_rd = (mirror_rd + 1) % RING_DEPTH;
               if (mirror_fill != 0) mirror_fill--;
               msg_bytes_left--;
               reply.last_byte = (msg_bytes_left == 0);
               msg_flag = (mirror_fill >= lim_min);
            end
         end
         OP_CLEAR: begin
            // contents stay, everything else goes back to empty
            mirror_wr = 0;
            mirror_rd = 0;
            mirror_fill = 0;
            chunk_bytes_left = 0;
            chunk_taken = 1'b0;
            msg_bytes_left = 0;
            msg_flag = 1'b0;
         end
      endcase
      reply.has_message = msg_flag;
      reply.fill_count = FILL_W'(mirror_fill);
      return emits;
   endfunction

   // idle cycles before the next item, with occasional stretches of none
   function automatic int unsigned pick_gap(inout int unsigned burst_left);
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // offer one request and predict its response once taken
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] data,
                               input logic [LEN_W-1:0] clen);
      int unsigned gap;
      rsp_type     reply;
      gap = pick_gap(send_burst_left);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.data_byte <= data;
      req_ch.chunk_length <= clen;
      do @(posedge clock); while (!req_ch.ready);
      last_reply_valid = compute_ring_reply(op, data, clen, reply);
      last_reply = reply;
      if (last_reply_valid) replies_due.push_back(reply);
      requests_sent++;
   endtask

   // request whose data and length fields are don't-care
   task automatic send_control(input logic [OPCODE_W-1:0] op);
      send_request(op, BYTE_W'($urandom), LEN_W'($urandom));
   endtask

   // stop offering and let every owed response come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write, then read back
   task automatic write_limit(input logic [REG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_HEAD_LEN: lim_head = value;
         REG_MIN_LEN:  lim_min = value;
         REG_MAX_LEN:  lim_max = value;
         default: begin
         end
      endcase
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field($sformatf("register %0d readback", idx), prdata, DATA_W'(value));
      psel <= 1'b0;
      penable <= 1'b0;
      // bus idle between transfers
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [LEN_W-1:0] head, input logic [LEN_W-1:0] min_fill,
                             input logic [LEN_W-1:0] max_len);
      wait_idle();
      write_limit(REG_HEAD_LEN, head);
      write_limit(REG_MIN_LEN, min_fill);
      write_limit(REG_MAX_LEN, max_len);
   endtask

   // header plus payload, cut into chunks of fixed or random size
   task automatic push_message(input int unsigned msg_len, input int unsigned n_bytes,
                               input int unsigned chunk_size);
      int unsigned      sent;
      int unsigned      piece;
      int unsigned      k;
      logic [LEN_W-1:0] header;
      logic [BYTE_W-1:0] value;
      header = LEN_W'(msg_len);
      sent = 0;
      while (sent < n_bytes) begin
         if (chunk_size != 0)
            piece = (n_bytes - sent < chunk_size) ? n_bytes - sent : chunk_size;
         else if ($urandom_range(0, 1) == 0)
            piece = n_bytes - sent;
         else
            piece = $urandom_range(1, n_bytes - sent);
         for (k = 0; k < piece; k++) begin
            if (sent == 0) value = header[15:8];
            else if (sent == 1) value = header[7:0];
            else value = BYTE_W'($urandom);
            // only the first byte of a chunk carries a meaningful length
            send_request(OP_PUSH, value, (k == 0) ? LEN_W'(piece) : LEN_W'($urandom));
            sent++;
         end
      end
   endtask

   // pop start, then read out whatever the ring says is pending
   task automatic pop_and_drain(input bit allow_early_stop);
      send_control(OP_POP);
      if (last_reply.status == ST_BAD_LENGTH && $urandom_range(0, 9) < 7)
         send_control(OP_CLEAR);
      while (msg_bytes_left != 0) begin
         if (allow_early_stop && $urandom_range(0, 39) == 0) break;
         if ($urandom_range(0, 29) == 0) send_control(OP_POP);
         send_control(OP_READ);
      end
   endtask

   // mostly well-formed messages, the rest noise
   task automatic random_traffic(input int unsigned n_requests);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      int unsigned msg_len;
      stop_at = requests_sent + n_requests;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         lo = lim_head;
         hi = (lim_max < lo + 24) ? lim_max : lo + 24;
         if (mirror_fill > 3000) begin
            send_control(OP_CLEAR);
         end else if (pick < 45) begin
            if (lo > hi || lo > 64 || $urandom_range(0, 9) == 0) begin
               // header the limits may refuse, followed by a few bytes
               msg_len = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
               push_message(msg_len, 2 + $urandom_range(0, 12), 0);
            end else begin
               msg_len = $urandom_range(lo, hi);
               push_message(msg_len, msg_len, 0);
            end
         end else if (pick < 78) begin
            pop_and_drain(1'b1);
         end else if (pick < 86) begin
            send_control(OP_READ);
         end else if (pick < 90) begin
            send_control(OP_CLEAR);
         end else if (pick < 94) begin
            send_request(OP_PUSH, BYTE_W'($urandom), '0);
         end else begin
            // stray short chunk that knocks messages out of step
            send_request(OP_PUSH, BYTE_W'($urandom), LEN_W'($urandom_range(1, 6)));
         end
      end
   endtask

   task automatic test_directed();
      send_control(OP_READ);
      send_control(OP_POP);
      send_request(OP_PUSH, 8'h5A, 16'h0000);
      // one header byte is below the head length
      send_request(OP_PUSH, 8'h00, 16'd1);
      send_control(OP_POP);
      send_request(OP_PUSH, 8'h05, 16'd2);
      send_request(OP_PUSH, 8'hAA, 16'hFFFF);
      // header says 5, only 3 held
      send_control(OP_POP);
      send_request(OP_PUSH, 8'hBB, 16'd2);
      send_request(OP_PUSH, 8'hFF, 16'h8000);
      send_control(OP_POP);
      send_control(OP_POP);
      repeat (5) send_control(OP_READ);
      send_control(OP_READ);
      // header of 1 is refused and stays at the head
      send_request(OP_PUSH, 8'h00, 16'd2);
      send_request(OP_PUSH, 8'h01, 16'h7FFF);
      send_control(OP_POP);
      send_control(OP_POP);
      send_control(OP_CLEAR);
   endtask

   task automatic test_limit_settings();
      set_limits(16'd2, 16'd0, 16'd2);
      random_traffic(60);
      set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_traffic(60);
      // head length above the maximum: every header is refused
      set_limits(16'd20, 16'd5, 16'd10);
      random_traffic(60);
      set_limits(LEN_W'($urandom_range(3, 12)), LEN_W'($urandom_range(0, 30)),
                 LEN_W'($urandom_range(12, 40)));
      random_traffic(60);
   endtask

   task automatic test_backpressure();
      set_limits(HEAD_LEN_RESET, MIN_LEN_RESET, MAX_LEN_RESET);
      hold_cycles_req = 400;
      send_control(OP_POP);
      random_traffic(40);
      wait_idle();
   endtask

   task automatic test_ring_wrap();
      set_limits(16'd2, 16'd4095, 16'hFFFF);
      send_control(OP_CLEAR);
      push_message(4000, 4000, 1000);
      // fills the ring to one below its depth
      push_message(95, 95, 95);
      send_request(OP_PUSH, 8'hC3, 16'd1);
      repeat (3) send_request(OP_PUSH, 8'h3C, 16'd3);
      pop_and_drain(1'b0);
      pop_and_drain(1'b0);
      // header straddles the end of the ring
      push_message(20, 20, 0);
      pop_and_drain(1'b0);
   endtask

   task automatic test_random_traffic();
      set_limits(HEAD_LEN_RESET, MIN_LEN_RESET, MAX_LEN_RESET);
      random_traffic(350);
      set_limits(16'd2, LEN_W'($urandom_range(0, 64)), LEN_W'($urandom_range(2, 200)));
      random_traffic(350);
      set_limits(LEN_W'($urandom_range(2, 8)), LEN_W'($urandom_range(0, 16)),
                 LEN_W'($urandom_range(16, 600)));
      random_traffic(350);
      set_limits(HEAD_LEN_RESET, MIN_LEN_RESET, MAX_LEN_RESET);
      random_traffic(350);
   endtask

   // response side: random stalls, long hold-offs on request, field checks
   initial begin
      int unsigned gap;
      rsp_type     want;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles_req != 0) begin
            rsp_ch.ready <= 1'b0;
            gap = hold_cycles_req;
            hold_cycles_req = 0;
            repeat (gap) @(posedge clock);
         end else begin
            gap = pick_gap(recv_burst_left);
            if (gap != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         responses_seen++;
         if (replies_due.size() == 0) begin
            report_mismatch($sformatf("response with none owed, status %0d", rsp_ch.status));
         end else begin
            want = replies_due.pop_front();
            status_seen[want.status]++;
            check_field("status", rsp_ch.status, want.status);
            check_field("message_length", rsp_ch.message_length, want.message_length);
            check_field("message_id", rsp_ch.message_id, want.message_id);
            check_field("data_out", rsp_ch.data_out, want.data_out);
            check_field("last_byte", rsp_ch.last_byte, want.last_byte);
            check_field("has_message", rsp_ch.has_message, want.has_message);
            check_field("fill_count", rsp_ch.fill_count, want.fill_count);
         end
      end
   end

   // reset, then the tests in turn
   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_PUSH;
      req_ch.data_byte <= '0;
      req_ch.chunk_length <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limit_settings();
      test_backpressure();
      test_ring_wrap();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("%0d requests, %0d responses over directed, limits, back-pressure, wrap, random",
               requests_sent, responses_seen);
      $display("statuses: ok %0d, rejected %0d, short %0d, bad length %0d, busy %0d, idle %0d",
               status_seen[ST_OK], status_seen[ST_REJECTED], status_seen[ST_SHORT],
               status_seen[ST_BAD_LENGTH], status_seen[ST_BUSY], status_seen[ST_IDLE]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/lpmr_pkg.sv
hw/rtl/lpmr_if.sv
hw/rtl/lpmr_ram.sv
hw/rtl/lpmr_csr.sv
hw/rtl/length_prefixed_message_ring.sv
hw/rtl/lpmr_checker.sv
test/length_prefixed_message_ring_test.sv
